/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
// Self-contained; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define AST_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
// Next-cycle implication, disabled during reset
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define AST_IMPL(lbl, clk, rst, ante, cons)
`define AST_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/vas_pkg.sv */
// Package for the VRAM access slot schedule decoder.
// Holds activity codes, schedule mode codes, slot constants and the result type.
`default_nettype none
package vas_pkg;

  localparam int unsigned SLOTS_PER_LINE = 171;
  // ceil(2^24 / 171): exact quotient for every 16-bit slot number
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [16:0] RECIP = 17'((1 << RECIP_SHIFT) / SLOTS_PER_LINE + 1);

  // Schedule modes
  localparam logic [1:0] MODE_REFRESH = 2'd0;
  localparam logic [1:0] MODE_GRAPHICS = 2'd1;
  localparam logic [1:0] MODE_TEXT = 2'd2;
  localparam logic [1:0] MODE_MULTI = 2'd3;

  // Activity codes
  localparam logic [3:0] ACT_CPU = 4'd0;
  localparam logic [3:0] ACT_REFRESH = 4'd1;
  localparam logic [3:0] ACT_NAME = 4'd2;
  localparam logic [3:0] ACT_COLOUR = 4'd3;
  localparam logic [3:0] ACT_PATTERN = 4'd4;
  localparam logic [3:0] ACT_SCAN_Y = 4'd5;
  localparam logic [3:0] ACT_SEL_Y = 4'd6;
  localparam logic [3:0] ACT_SEL_X = 4'd7;
  localparam logic [3:0] ACT_SEL_NAME = 4'd8;
  localparam logic [3:0] ACT_SEL_COLOUR = 4'd9;
  localparam logic [3:0] ACT_SEL_PATTERN = 4'd10;
  localparam logic [3:0] ACT_UNKNOWN = 4'd11;

  typedef struct packed {
    logic [3:0] act;
    logic [5:0] idx;
    logic       sel;
  } access_t;

endpackage
`default_nettype wire

/* rtl/core/vram_access_slot_schedule.sv */
// VRAM access slot schedule decoder: slot number in, owning access out.
// Depends on vas_pkg and assert_macros.svh.
// One slot accepted every cycle (busy stays low); start->valid_a->valid_b->done.
// Stage 1 multiplies by the reciprocal of 171, stage 2 forms the remainder,
// stage 3 decodes the schedule. Results are strobed and cannot be stalled.
// Synchronous reset clears the pipeline valid bits and sets the refresh schedule.
`default_nettype none
`include "assert_macros.svh"
module vram_access_slot_schedule
  import vas_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] slot_number,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  output logic             done,
  output logic [3:0]       activity,
  output logic [5:0]       fetch_index,
  output logic             byte_select,
  output logic             cpu_slot
);

  // One selected sprite: y, x, name, colour, pattern 0, pattern 1
  function automatic access_t sprite_step(input logic [2:0] step, input logic [5:0] spr);
    access_t a;
    a.idx = spr;
    a.sel = 1'b0;
    case (step)
      3'd0:    a.act = ACT_SEL_Y;
      3'd1:    a.act = ACT_SEL_X;
      3'd2:    a.act = ACT_SEL_NAME;
      3'd3:    a.act = ACT_SEL_COLOUR;
      3'd4:    a.act = ACT_SEL_PATTERN;
      default: begin
        a.act = ACT_SEL_PATTERN;
        a.sel = 1'b1;
      end
    endcase
    return a;
  endfunction

  localparam logic [7:0] SLOTS = 8'(SLOTS_PER_LINE);

  logic [1:0]  schedule_mode;

  // stage 1 registers
  logic        valid_a;
  logic [15:0] slot_a;
  logic [1:0]  mode_a;
  logic [8:0]  quot_a;
  // stage 2 registers
  logic        valid_b;
  logic [7:0]  rem_b;
  logic [1:0]  mode_b;

  logic [32:0] prod;
  logic [16:0] quot_x_slots;
  logic [15:0] rem_full;
  access_t     result_next;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      schedule_mode <= MODE_REFRESH;
    end else if (cfg_valid && cfg_ready) begin
      schedule_mode <= cfg_data;
    end
  end

  // Stage 1: quotient by reciprocal multiply
  assign prod = 33'(slot_number) * 33'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= start && !busy;
    end
    slot_a <= slot_number;
    mode_a <= schedule_mode;
    quot_a <= prod[RECIP_SHIFT +: 9];
  end

  // Stage 2: remainder
  assign quot_x_slots = 17'(quot_a) * 17'(SLOTS);
  assign rem_full = slot_a - quot_x_slots[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= valid_a;
    end
    rem_b <= rem_full[7:0];
    mode_b <= mode_a;
  end

  // Stage 3: schedule decode
  always_comb begin
    logic [7:0]  s;
    logic [7:0]  g;
    logic [4:0]  gc;
    logic [5:0]  gc3;
    logic [7:0]  spd;
    logic [7:0]  tt;
    logic [12:0] tprod;
    logic [5:0]  tc;
    logic [6:0]  tr;
    access_t     gr;
    access_t     rf;
    access_t     tx;

    s = rem_b;

    // refresh schedule
    if (s <= 8'd26 || (s >= 8'd28 && s <= 8'd152 && !s[0]) || s >= 8'd154) begin
      rf = '{act: ACT_CPU, idx: 6'd0, sel: 1'b0};
    end else begin
      rf = '{act: ACT_REFRESH, idx: 6'd0, sel: 1'b0};
    end

    // graphics schedule
    g = s - 8'd27;
    gc = g[6:2];
    gc3 = {1'b0, gc} + 6'd3;
    spd = s - 8'd157;
    if (s <= 8'd4 || (s >= 8'd15 && s <= 8'd18) || s == 8'd155 || s == 8'd156) begin
      gr = '{act: ACT_CPU, idx: 6'd0, sel: 1'b0};
    end else if (s >= 8'd5 && s <= 8'd8) begin
      // finishing sprite 2 begun at the end of the previous line
      gr = sprite_step(3'(s - 8'd3), 6'd2);
    end else if (s >= 8'd9 && s <= 8'd14) begin
      gr = sprite_step(3'(s - 8'd9), 6'd3);
    end else if (s >= 8'd19 && s <= 8'd26) begin
      gr = '{act: ACT_SCAN_Y, idx: 6'(s - 8'd19), sel: 1'b0};
    end else if (s >= 8'd27 && s <= 8'd154) begin
      case (g[1:0])
        2'd0: gr = '{act: ACT_NAME, idx: {1'b0, gc}, sel: 1'b0};
        2'd1: begin
          // every fourth column hands its scan slot to the CPU
          if (gc[1:0] == 2'd0) begin
            gr = '{act: ACT_CPU, idx: 6'd0, sel: 1'b0};
          end else begin
            gr = '{act: ACT_SCAN_Y, idx: 6'd8 + {1'b0, gc} - (gc3 >> 2), sel: 1'b0};
          end
        end
        2'd2: gr = '{act: ACT_COLOUR, idx: {1'b0, gc}, sel: 1'b0};
        default: gr = '{act: ACT_PATTERN, idx: {1'b0, gc}, sel: 1'b0};
      endcase
    end else if (s >= 8'd157 && s <= 8'd168) begin
      if (spd < 8'd6) begin
        gr = sprite_step(spd[2:0], 6'd0);
      end else begin
        gr = sprite_step(3'(spd - 8'd6), 6'd1);
      end
    end else if (s == 8'd169 || s == 8'd170) begin
      gr = sprite_step(3'(s - 8'd169), 6'd2);
    end else begin
      gr = '{act: ACT_UNKNOWN, idx: 6'd0, sel: 1'b0};
    end

    // text schedule: divide by three via multiply by 43/128
    tt = s - 8'd30;
    tprod = 13'(tt[6:0]) * 13'd43;
    tc = tprod[12:7];
    tr = tt[6:0] - ({1'b0, tc} + {tc, 1'b0});
    if (s <= 8'd29 || s >= 8'd150) begin
      tx = '{act: ACT_CPU, idx: 6'd0, sel: 1'b0};
    end else begin
      case (tr[1:0])
        2'd0:    tx = '{act: ACT_NAME, idx: tc, sel: 1'b0};
        2'd2:    tx = '{act: ACT_PATTERN, idx: tc, sel: 1'b0};
        default: tx = '{act: ACT_CPU, idx: 6'd0, sel: 1'b0};
      endcase
    end

    unique case (mode_b)
      MODE_REFRESH:  result_next = rf;
      MODE_GRAPHICS: result_next = gr;
      MODE_TEXT:     result_next = tx;
      default: begin
        // multicolour: colour fetches go to the CPU
        if (gr.act == ACT_COLOUR) begin
          result_next = '{act: ACT_CPU, idx: 6'd0, sel: 1'b0};
        end else begin
          result_next = gr;
        end
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_b;
    end
    activity <= result_next.act;
    fetch_index <= result_next.idx;
    byte_select <= result_next.sel;
    cpu_slot <= (result_next.act == ACT_CPU);
  end

  // Checks
  `AST_NEXT(a_latency, clk, rst, start && !busy, valid_a ##1 valid_b ##1 done)
  `AST_IMPL(a_rem_range, clk, rst, valid_b, rem_b < SLOTS)
  `AST_IMPL(a_cpu_flag, clk, rst, done, cpu_slot == (activity == ACT_CPU))
  `AST_IMPL(a_sel_pattern, clk, rst, done && byte_select, activity == ACT_SEL_PATTERN)

endmodule
`default_nettype wire

/* verif/vas_slot_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the VRAM access slot schedule decoder: keeps its own copy of
// the schedule register, works out the owner of every accepted slot and checks
// each done strobe against the oldest outstanding slot. Depends on vas_pkg.
module vas_slot_checker
  import vas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] slot_number,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        done,
  input  logic [3:0]  activity,
  input  logic [5:0]  fetch_index,
  input  logic        byte_select,
  input  logic        cpu_slot,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [3:0] act;
    logic [5:0] idx;
    logic       sel;
    logic       cpu;
  } slot_owner_t;

  logic [1:0]  mode_mirror;
  slot_owner_t owner_q[$];

  function automatic slot_owner_t owner(logic [3:0] act, int unsigned idx, logic sel);
    slot_owner_t o;
    o.act = act;
    o.idx = 6'(idx);
    o.sel = sel;
    o.cpu = (act == ACT_CPU);
    return o;
  endfunction

  // Six slots per selected sprite: y, x, name, colour, pattern byte 0 and 1
  function automatic slot_owner_t sprite_fetch(int unsigned step, int unsigned sprite);
    case (step)
      0: return owner(ACT_SEL_Y, sprite, 1'b0);
      1: return owner(ACT_SEL_X, sprite, 1'b0);
      2: return owner(ACT_SEL_NAME, sprite, 1'b0);
      3: return owner(ACT_SEL_COLOUR, sprite, 1'b0);
      4: return owner(ACT_SEL_PATTERN, sprite, 1'b0);
      default: return owner(ACT_SEL_PATTERN, sprite, 1'b1);
    endcase
  endfunction

  function automatic slot_owner_t refresh_owner(int unsigned s);
    if (s <= 26 || (s >= 28 && s <= 152 && s % 2 == 0) || s >= 154)
      return owner(ACT_CPU, 0, 1'b0);
    return owner(ACT_REFRESH, 0, 1'b0);
  endfunction

  function automatic slot_owner_t graphics_owner(int unsigned s);
    int unsigned col;
    if (s <= 4 || (s >= 15 && s <= 18) || s == 155 || s == 156)
      return owner(ACT_CPU, 0, 1'b0);
    // slots 5..8 finish sprite 2, begun at the end of the previous line
    if (s >= 5 && s <= 8)
      return sprite_fetch(s - 3, 2);
    if (s >= 9 && s <= 14)
      return sprite_fetch(s - 9, 3);
    if (s >= 19 && s <= 26)
      return owner(ACT_SCAN_Y, s - 19, 1'b0);
    if (s >= 27 && s <= 154) begin
      col = (s - 27) >> 2;
      case ((s - 27) & 3)
        0: return owner(ACT_NAME, col, 1'b0);
        1: begin
          // every fourth column hands its scan slot to the CPU
          if (col % 4 == 0)
            return owner(ACT_CPU, 0, 1'b0);
          return owner(ACT_SCAN_Y, 8 + col - ((col + 3) >> 2), 1'b0);
        end
        2: return owner(ACT_COLOUR, col, 1'b0);
        default: return owner(ACT_PATTERN, col, 1'b0);
      endcase
    end
    if (s >= 157 && s <= 168)
      return sprite_fetch((s - 157) % 6, (s - 157) / 6);
    if (s >= 169 && s <= 170)
      return sprite_fetch(s - 169, 2);
    return owner(ACT_UNKNOWN, 0, 1'b0);
  endfunction

  function automatic slot_owner_t text_owner(int unsigned s);
    int unsigned col;
    if (s <= 29 || s >= 150)
      return owner(ACT_CPU, 0, 1'b0);
    col = (s - 30) / 3;
    case ((s - 30) % 3)
      0: return owner(ACT_NAME, col, 1'b0);
      1: return owner(ACT_CPU, 0, 1'b0);
      default: return owner(ACT_PATTERN, col, 1'b0);
    endcase
  endfunction

  function automatic slot_owner_t predict_owner(logic [1:0] mode, logic [15:0] raw);
    int unsigned s;
    slot_owner_t o;
    s = int'(raw) % SLOTS_PER_LINE;
    case (mode)
      MODE_REFRESH:  o = refresh_owner(s);
      MODE_GRAPHICS: o = graphics_owner(s);
      MODE_TEXT:     o = text_owner(s);
      default: begin
        // multicolour: graphics timing, colour slots go to the CPU
        o = graphics_owner(s);
        if (o.act == ACT_COLOUR)
          o = owner(ACT_CPU, 0, 1'b0);
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] slot check: %s", $time, msg);
    errors++;
  endtask

  // Track config and slot beats, compare each strobed result
  always @(posedge clk) begin
    slot_owner_t want;
    if (rst) begin
      mode_mirror = MODE_REFRESH;
      owner_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        mode_mirror = cfg_data;
      if (start && !busy)
        owner_q.push_back(predict_owner(mode_mirror, slot_number));
      if (done) begin
        if (owner_q.size() == 0) begin
          report_mismatch("done strobe with no slot outstanding");
        end else begin
          want = owner_q.pop_front();
          if (activity !== want.act)
            report_mismatch($sformatf("activity %0d, want %0d", activity, want.act));
          if (fetch_index !== want.idx)
            report_mismatch($sformatf("fetch_index %0d, want %0d", fetch_index, want.idx));
          if (byte_select !== want.sel)
            report_mismatch($sformatf("byte_select %0b, want %0b", byte_select, want.sel));
          if (cpu_slot !== want.cpu)
            report_mismatch($sformatf("cpu_slot %0b, want %0b", cpu_slot, want.cpu));
        end
      end
      pending <= owner_q.size();
    end
  end

endmodule

/* verif/tb_vram_access_slot_schedule.sv */
`timescale 1ns / 1ps
// Top of the slot schedule testbench: clock, reset, slot and schedule stimulus.
// Depends on vas_pkg, the decoder and vas_slot_checker.
module tb_vram_access_slot_schedule;
  import vas_pkg::*;

  localparam int SLOT_TARGET = 750;
  localparam int LATENCY     = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] slot_number = '0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_data = MODE_REFRESH;
  logic        busy;
  logic        cfg_ready;
  logic        done;
  logic [3:0]  activity;
  logic [5:0]  fetch_index;
  logic        byte_select;
  logic        cpu_slot;
  int          errors;
  int          pending;
  int          slots_sent = 0;
  int          phase_count = 0;
  logic [15:0] line_ctr = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vram_access_slot_schedule dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .slot_number (slot_number),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .activity    (activity),
    .fetch_index (fetch_index),
    .byte_select (byte_select),
    .cpu_slot    (cpu_slot)
  );

  vas_slot_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .slot_number (slot_number),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .activity    (activity),
    .fetch_index (fetch_index),
    .byte_select (byte_select),
    .cpu_slot    (cpu_slot),
    .errors      (errors),
    .pending     (pending)
  );

  // One slot beat; start stays high if the next beat follows straight on
  task automatic send_slot(logic [15:0] slot);
    start <= 1'b1;
    slot_number <= slot;
    do @(posedge clk); while (busy);
    slots_sent++;
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait until every slot has come back and the pipeline is empty
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mix of counter runs, raw 16-bit values and slots around a line boundary
  function automatic logic [15:0] next_slot();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      line_ctr = line_ctr + 16'd1;
      return line_ctr;
    end
    if (kind < 8)
      return 16'($urandom);
    return 16'(SLOTS_PER_LINE * $urandom_range(1, 383) + $urandom_range(0, 2) - 1);
  endfunction

  initial begin
    logic [15:0] directed [22];
    logic [1:0]  mode_plan [4];
    logic [1:0]  mode;
    int          n_items;
    int          burst;
    int          sent_in_phase;
    bit          no_gaps;

    // line edges, sprite wrap, every-fourth scan slot, field extremes
    directed = '{16'd0, 16'd4, 16'd5, 16'd8, 16'd9, 16'd14, 16'd18, 16'd19,
                 16'd26, 16'd27, 16'd28, 16'd31, 16'd43, 16'd154, 16'd155, 16'd156,
                 16'd157, 16'd168, 16'd169, 16'd170, 16'd171, 16'hFFFF};
    mode_plan = '{MODE_REFRESH, MODE_TEXT, MODE_MULTI, MODE_GRAPHICS};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_mode(MODE_GRAPHICS);
    foreach (directed[i])
      send_slot(directed[i]);
    drain();

    // Random phases, each under its own schedule
    while (slots_sent < SLOT_TARGET) begin
      mode = (phase_count < 4) ? mode_plan[phase_count] : 2'($urandom_range(0, 3));
      write_mode(mode);
      n_items = $urandom_range(40, 100);
      no_gaps = ($urandom_range(0, 3) == 0);
      sent_in_phase = 0;
      while (sent_in_phase < n_items) begin
        burst = $urandom_range(1, 16);
        for (int b = 0; b < burst && sent_in_phase < n_items; b++) begin
          send_slot(next_slot());
          sent_in_phase++;
        end
        if (!no_gaps && $urandom_range(0, 2) != 0)
          hold_off($urandom_range(1, 5));
      end
      drain();
      phase_count++;
    end

    repeat (2 * LATENCY) @(posedge clk);
    $display("Sent %0d slot beats over %0d random phases plus a directed set;",
             slots_sent, phase_count);
    $display("refresh, graphics, text and multicolour schedules all exercised.");
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timed out with %0d slots outstanding", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule
